[rtl/lmfd_pkg.sv]
// Shared types and constants for the LED matrix frame driver.
// Used by the top module and the row update unit; depends on nothing else.
package lmfd_pkg;

    // Command codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_RECT  = 2'd2;

    // Device register addresses and the fixed normal-mode word
    localparam logic [7:0]  ADDR_DECODE    = 8'h09;
    localparam logic [7:0]  ADDR_INTENSITY = 8'h0A;
    localparam logic [7:0]  ADDR_SCAN      = 8'h0B;
    localparam logic [15:0] WORD_NORMAL    = 16'h0C01;

    // Configuration register indexes
    localparam logic [1:0] CFG_DECODE    = 2'd0;
    localparam logic [1:0] CFG_INTENSITY = 2'd1;
    localparam logic [1:0] CFG_SCAN      = 2'd2;

    // Latched command as it travels to the row update unit
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] row;
        logic [2:0] col;
        logic       pixel_value;
        logic [3:0] box_width;
        logic [3:0] box_height;
    } lmfd_cmd_t;

endpackage

[rtl/led_matrix_frame_driver_unit.sv]
// LED matrix frame driver. Each accepted init, pixel or rectangle command produces
// a burst of 16-bit device words (address << 8 | data), one word per cycle while the
// output is not stalled: init gives 4 set-up words then ROWS zero row words; pixel
// and rectangle update the frame buffer and give ROWS row words. After the accepting
// cycle a command occupies the block until its last word is registered, paced by the
// row sequencer that walks the buffer one row per cycle while the output is not
// stalled, through the single row update unit; no new command is taken meanwhile.
// An unused command code is taken and dropped. cmd_stall is high until the last word
// of a burst has been registered; the last word of a burst carries last = 1.
module led_matrix_frame_driver_unit #(
    parameter int ROWS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  row,
    input  logic [2:0]  col,
    input  logic        pixel_value,
    input  logic [3:0]  box_width,
    input  logic [3:0]  box_height,
    // Device word channel
    output logic        dev_valid,
    input  logic        dev_stall,
    output logic [15:0] word,
    output logic        last,
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lmfd_pkg::*;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       setup_reg, setup_next;
    logic [ROW_W-1:0] row_reg, row_next;
    lmfd_cmd_t        cmd_reg, cmd_next;
    logic [7:0]       decode_reg;
    logic [3:0]       intensity_reg;
    logic [2:0]       scan_reg;
    logic             valid_reg, valid_next;
    logic [15:0]      word_reg, word_next;
    logic             last_reg, last_next;

    logic             accept;
    logic             advance;
    logic             frame_we;
    logic [7:0]       cur_byte;
    logic [7:0]       new_byte;
    logic [15:0]      setup_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_reg    <= 8'd0;
            intensity_reg <= 4'd15;
            scan_reg      <= 3'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DECODE:    decode_reg    <= cfg_data;
                CFG_INTENSITY: intensity_reg <= cfg_data[3:0];
                CFG_SCAN:      scan_reg      <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    lmfd_frame_buf #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (row_reg),
        .wr_en   (frame_we),
        .wr_data (new_byte),
        .rd_data (cur_byte)
    );

    lmfd_row_unit #(
        .ROW_W (ROW_W)
    ) u_row (
        .cmd      (cmd_reg),
        .row_idx  (row_reg),
        .cur_byte (cur_byte),
        .new_byte (new_byte)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign advance   = (state_reg != ST_IDLE) && (!valid_reg || !dev_stall);
    assign frame_we  = advance && (state_reg == ST_ROWS) && (cmd_reg.op != OP_INIT);

    // Select the set-up word for the current init step
    always_comb
    begin
        unique case (setup_reg)
            2'd0:    setup_word = {ADDR_DECODE, decode_reg};
            2'd1:    setup_word = {ADDR_INTENSITY, 4'd0, intensity_reg};
            2'd2:    setup_word = {ADDR_SCAN, 5'd0, scan_reg};
            default: setup_word = WORD_NORMAL;
        endcase
    end

    // Sequence the burst and fill the output register
    always_comb
    begin
        state_next = state_reg;
        setup_next = setup_reg;
        row_next   = row_reg;
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        last_next  = last_reg;

        if (valid_reg && !dev_stall)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = '{op: operation, row: row, col: col,
                                 pixel_value: pixel_value,
                                 box_width: box_width, box_height: box_height};
                    setup_next = 2'd0;
                    row_next   = '0;
                    case (operation) inside
                        OP_INIT:           state_next = ST_SETUP;
                        OP_PIXEL, OP_RECT: state_next = ST_ROWS;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    word_next  = setup_word;
                    last_next  = 1'b0;
                    setup_next = setup_reg + 2'd1;
                    if (setup_reg == 2'd3)
                    begin
                        state_next = ST_ROWS;
                    end
                end
            end
            ST_ROWS:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    word_next  = {8'(row_reg) + 8'd1,
                                  (cmd_reg.op == OP_INIT) ? 8'd0 : new_byte};
                    last_next  = (row_reg == LAST_ROW);
                    if (row_reg == LAST_ROW)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            setup_reg <= 2'd0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            setup_reg <= setup_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign dev_valid = valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

endmodule

[rtl/lmfd_row_unit.sv]
// Row update unit: computes the new byte of one frame row for the latched command.
// Shared across all rows by the sequencer; depends on lmfd_pkg.
module lmfd_row_unit #(
    parameter int ROW_W = 3
) (
    input  lmfd_pkg::lmfd_cmd_t cmd,
    input  logic [ROW_W-1:0]    row_idx,
    input  logic [7:0]          cur_byte,
    output logic [7:0]          new_byte
);
    import lmfd_pkg::*;

    logic [4:0] r5;
    logic [4:0] top5;
    logic [4:0] bot_lim5;
    logic [4:0] col5;
    logic [4:0] right_lim5;
    logic       on_horiz;
    logic       in_vert;
    logic [7:0] rect_mask;
    logic [7:0] pix_mask;

    // Row-relative conditions, kept non-negative by comparing against bound + 1
    assign r5         = 5'(row_idx);
    assign top5       = 5'(cmd.row);
    assign bot_lim5   = 5'(cmd.row) + 5'(cmd.box_height);
    assign col5       = 5'(cmd.col);
    assign right_lim5 = 5'(cmd.col) + 5'(cmd.box_width);
    assign on_horiz   = (cmd.box_width != 4'd0) &&
                        ((r5 == top5) || ((r5 + 5'd1) == bot_lim5));
    assign in_vert    = (r5 >= top5) && (r5 < bot_lim5);

    // Outline columns touched in this row; column 0 is the MSB
    always_comb
    begin
        rect_mask = 8'd0;
        for (int c = 0; c < 8; c++)
        begin
            if (on_horiz && (5'(c) >= col5) && (5'(c) < right_lim5))
            begin
                rect_mask[7-c] = 1'b1;
            end
            if (in_vert && ((5'(c) == col5) || ((5'(c) + 5'd1) == right_lim5)))
            begin
                rect_mask[7-c] = 1'b1;
            end
        end
    end

    assign pix_mask = 8'h80 >> cmd.col;

    // Apply the command to the current row byte
    always_comb
    begin
        unique case (cmd.op)
            OP_PIXEL:
            begin
                if (r5 == top5)
                begin
                    new_byte = cmd.pixel_value ? (cur_byte | pix_mask)
                                               : (cur_byte & ~pix_mask);
                end
                else
                begin
                    new_byte = cur_byte;
                end
            end
            OP_RECT:  new_byte = cur_byte | rect_mask;
            default:  new_byte = cur_byte;
        endcase
    end

endmodule

[rtl/lmfd_frame_buf.sv]
// Frame buffer: one byte per matrix row, cleared at reset.
// Read and written at the row the sequencer points to; depends on nothing else.
module lmfd_frame_buf #(
    parameter int ROWS  = 8,
    parameter int ROW_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ROW_W-1:0] idx,
    input  logic             wr_en,
    input  logic [7:0]       wr_data,
    output logic [7:0]       rd_data
);

    logic [7:0] rows_reg [ROWS];

    // Store the updated row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                rows_reg[i] <= 8'd0;
            end
        end
        else if (wr_en)
        begin
            rows_reg[idx] <= wr_data;
        end
    end

    assign rd_data = rows_reg[idx];

endmodule
